// ===== rtl/core/wfd_pkg.sv =====
package wfd_pkg;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_MASK = 2'd1;
  localparam logic [1:0] ERR_LEN  = 2'd2;

  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_CLOSE = 4'h8;

  localparam logic [6:0] LEN_EXT16 = 7'd126;

  localparam logic [2:0] CNT_MASK  = 3'd4;
  localparam logic [2:0] CNT_EXT16 = 3'd2;
  // eight bytes: the counter wraps through zero
  localparam logic [2:0] CNT_EXT64 = 3'd0;

  localparam logic        REG_MAX_MSG     = 1'b0;
  localparam logic [31:0] MAX_MSG_RST_VAL = 32'd1048576;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       message_last;
    logic [3:0] message_opcode;
    logic [1:0] error_code;
    logic       closed;
  } wfd_item_t;

  typedef struct packed {
    logic      valid;
    wfd_item_t item;
  } wfd_push_t;

endpackage

// ===== rtl/core/websocket_frame_deframer_core.sv =====
// A byte passes the input register, then the result queue, before its result can be accepted.
// Throughput: one byte per cycle while the queue has room; header, length and mask bytes
// give no result save a mask or length error or an empty final frame. in_ready drops only
// while the input register holds a byte and the two-entry result queue is full.
// Reset (synchronous, rst_n low): parser to first header byte, queue empty,
// max_message_size to 1048576.
module websocket_frame_deframer_core #(
  parameter int MSG_LEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_valid,
  output logic        out_message_last,
  output logic [3:0]  out_message_opcode,
  output logic [1:0]  out_error_code,
  output logic        out_closed,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wfd_pkg::*;

  logic [31:0] max_msg;
  logic        q_full;
  wfd_push_t   push;
  wfd_item_t   item;

  wfd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .max_msg_o  (max_msg)
  );

  wfd_parser #(
    .MSG_LEN_BITS(MSG_LEN_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .max_msg_i   (max_msg),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  wfd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .q_full_o (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .item_o   (item)
  );

  assign out_payload_byte   = item.payload_byte;
  assign out_byte_valid     = item.byte_valid;
  assign out_message_last   = item.message_last;
  assign out_message_opcode = item.message_opcode;
  assign out_error_code     = item.error_code;
  assign out_closed         = item.closed;

endmodule

// ===== rtl/core/wfd_cfg.sv =====
module wfd_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [31:0] max_msg_o
);
  import wfd_pkg::*;

  logic [31:0] max_msg_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_MAX_MSG);
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_MSG) ? max_msg_r : 32'd0;
  assign max_msg_o  = max_msg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r <= MAX_MSG_RST_VAL;
    end else if (wr_en) begin
      max_msg_r <= cfg_pwdata;
    end
  end

endmodule

// ===== rtl/core/wfd_parser.sv =====
module wfd_parser #(
  parameter int MSG_LEN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic [31:0]         max_msg_i,
  input  logic                q_full_i,
  output wfd_pkg::wfd_push_t  push_o
);
  import wfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_MASK, PH_DATA, PH_ERR_MASK, PH_ERR_LEN, PH_CLOSED
  } phase_t;

  localparam logic [63:0] LEN_CAP = {64{1'b1}} >> (64 - MSG_LEN_BITS);

  phase_t                    phase_r, phase_nxt;
  logic                      in_v_r, in_v_nxt;
  logic [7:0]                in_b_r;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      fin_r, fin_nxt;
  logic [3:0]                op_r, op_nxt;
  logic [31:0]               key_r, key_nxt;
  logic [1:0]                mp_r, mp_nxt;
  logic [63:0]               fr_r, fr_nxt;
  logic [MSG_LEN_BITS-1:0]   ml_r, ml_nxt;
  logic                      adv;
  logic                      accept;
  logic [63:0]               cfg64;
  logic [63:0]               lim64;
  logic [64:0]               sum;
  logic                      too_long;
  logic [7:0]                key_byte;
  logic                      is_close;
  wfd_push_t                 push;

  assign accept   = in_valid && in_ready;
  assign in_ready = !in_v_r || !q_full_i;
  assign adv      = in_v_r && !q_full_i;

  assign cfg64    = 64'(max_msg_i);
  assign lim64    = (cfg64 > LEN_CAP) ? LEN_CAP : cfg64;
  assign sum      = {1'b0, fr_r} + 65'(ml_r);
  assign too_long = sum > {1'b0, lim64};
  assign key_byte = key_r[{~mp_r, 3'b000} +: 8];
  assign is_close = (op_r == OPC_CLOSE);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    mp_nxt    = mp_r;
    fr_nxt    = fr_r;
    ml_nxt    = ml_r;
    push      = '0;
    push.item.message_opcode = op_r;
    in_v_nxt  = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    if (adv) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt = in_b_r[7];
          if (in_b_r[3:0] != OPC_CONT) begin
            op_nxt = in_b_r[3:0];
          end
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          if (!in_b_r[7]) begin
            phase_nxt = PH_ERR_MASK;
            push.valid = 1'b1;
            push.item.error_code = ERR_MASK;
          end else begin
            key_nxt = '0;
            if (in_b_r[6:0] < LEN_EXT16) begin
              fr_nxt    = 64'(in_b_r[6:0]);
              cnt_nxt   = CNT_MASK;
              phase_nxt = PH_MASK;
            end else begin
              fr_nxt    = '0;
              cnt_nxt   = (in_b_r[6:0] == LEN_EXT16) ? CNT_EXT16 : CNT_EXT64;
              phase_nxt = PH_EXT;
            end
          end
        end
        PH_EXT: begin
          fr_nxt  = {fr_r[55:0], in_b_r};
          cnt_nxt = cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            cnt_nxt   = CNT_MASK;
            phase_nxt = PH_MASK;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_b_r};
          cnt_nxt = cnt_r - 3'd1;
          if (cnt_r == 3'd1) begin
            if (too_long) begin
              phase_nxt = PH_ERR_LEN;
              push.valid = 1'b1;
              push.item.error_code = ERR_LEN;
            end else begin
              ml_nxt = sum[MSG_LEN_BITS-1:0];
              mp_nxt = 2'd0;
              if (fr_r == 64'd0) begin
                phase_nxt = PH_HDR0;
                if (fin_r) begin
                  ml_nxt = '0;
                  push.valid = 1'b1;
                  push.item.message_last = 1'b1;
                  push.item.closed = is_close;
                  phase_nxt = is_close ? PH_CLOSED : PH_HDR0;
                end
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          push.valid = 1'b1;
          push.item.byte_valid = 1'b1;
          push.item.payload_byte = in_b_r ^ key_byte;
          mp_nxt = mp_r + 2'd1;
          fr_nxt = fr_r - 64'd1;
          if (fr_r == 64'd1) begin
            phase_nxt = PH_HDR0;
            if (fin_r) begin
              ml_nxt = '0;
              push.item.message_last = 1'b1;
              push.item.closed = is_close;
              phase_nxt = is_close ? PH_CLOSED : PH_HDR0;
            end
          end
        end
        PH_ERR_MASK: begin
          push.valid = 1'b1;
          push.item.error_code = ERR_MASK;
        end
        PH_ERR_LEN: begin
          push.valid = 1'b1;
          push.item.error_code = ERR_LEN;
        end
        default: begin
        end
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      in_v_r  <= 1'b0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      op_r    <= '0;
      key_r   <= '0;
      mp_r    <= '0;
      fr_r    <= '0;
      ml_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      in_v_r  <= in_v_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      op_r    <= op_nxt;
      key_r   <= key_nxt;
      mp_r    <= mp_nxt;
      fr_r    <= fr_nxt;
      ml_r    <= ml_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_b_r <= in_data_byte;
    end
  end

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLOSED |=> phase_r == PH_CLOSED)
    else $error("closed state left");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERR_MASK || phase_r == PH_ERR_LEN) |=> $stable(phase_r))
    else $error("error state left");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.item.byte_valid) |-> push.item.error_code == ERR_NONE)
    else $error("data item carries an error");

  a_no_push_closed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLOSED |-> !push.valid)
    else $error("item after close");

endmodule

// ===== rtl/core/wfd_outq.sv =====
module wfd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  wfd_pkg::wfd_push_t push_i,
  output logic               q_full_o,
  output logic               out_valid,
  input  logic               out_ready,
  output wfd_pkg::wfd_item_t item_o
);
  import wfd_pkg::*;

  wfd_item_t  ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign q_full_o  = (cnt_r == 2'd2);
  assign pop       = out_valid && out_ready;
  assign item_o    = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i.valid && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_i.valid && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i.valid) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      ent_r[wp_r] <= push_i.item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.valid |-> cnt_r != 2'd2)
    else $error("push into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("queue pointers disagree with count");

endmodule
